>>> src/merge_sort_engine_defines.svh
`ifndef MERGE_SORT_ENGINE_DEFINES_SVH
`define MERGE_SORT_ENGINE_DEFINES_SVH

// Concurrent checks used by the sort engine sequencer.
// The condition on the right must hold in the same cycle as the one on the left.
`define MSE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The condition on the right must hold in the cycle after the one on the left.
`define MSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/mse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mse_pkg;

	localparam int MAX_ITEMS_DEF  = 64;
	localparam int VALUE_BITS_DEF = 32;
	localparam int PORT_BITS      = 32;

	typedef struct packed {
		logic signed [PORT_BITS-1:0] item_value;
		logic                        item_last;
	} mse_item_t;

	typedef struct packed {
		logic signed [PORT_BITS-1:0] sorted_value;
		logic                        sorted_last;
		logic                        items_dropped;
	} mse_result_t;

	// Status that travels with each result transaction.
	typedef struct packed {
		logic valid;
		logic last;
		logic dropped;
	} mse_flags_t;

endpackage

`default_nettype wire

>>> src/merge_sort_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Sorts a set of signed values ascending.
// Input: drive item and raise start; the transaction is taken at a clock edge
// where start is high and busy is low. item_last marks the final value of a set.
// Up to MAX_ITEMS values are held; further values are discarded and every
// result of that set then carries items_dropped.
// Loading takes one value per cycle. After the final value busy stays high
// while the set is merged between two RAMs in ceil(log2(n)) passes, one element
// written per cycle through the single write port, with a priming state before
// each run pair. Readout then gives one result per cycle, marked by strobe,
// smallest first, sorted_last on the greatest; the first result follows the last
// merge cycle through the S_OUT state and the registered RAM read.
// The receiver cannot hold results off: each result is valid for exactly
// the one cycle in which strobe is high.
// Reset clears the item count, drop flag and sequencer; RAM contents are not
// cleared, and only entries written for the current set are used.

module merge_sort_engine import mse_pkg::*; #(
	parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire mse_item_t   item,
	output logic             strobe,
	output mse_result_t      result
);

	localparam int AW = $clog2(MAX_ITEMS);

	logic [VALUE_BITS-1:0] load_value;
	logic [VALUE_BITS-1:0] out_value;
	logic [AW-1:0]         rd0_addr;
	logic [AW-1:0]         rd1_addr;
	logic                  rd_b;
	logic                  rd_b_s1;
	logic [VALUE_BITS-1:0] rd0_data;
	logic [VALUE_BITS-1:0] rd1_data;
	logic [VALUE_BITS-1:0] a0_data;
	logic [VALUE_BITS-1:0] a1_data;
	logic [VALUE_BITS-1:0] b0_data;
	logic [VALUE_BITS-1:0] b1_data;
	logic                  wr_en;
	logic                  wr_b;
	logic [AW-1:0]         wr_addr;
	logic [VALUE_BITS-1:0] wr_data;
	mse_flags_t            flags;

	generate
		if (VALUE_BITS > PORT_BITS) begin : g_wide
			assign load_value = {{(VALUE_BITS - PORT_BITS){item.item_value[PORT_BITS-1]}},
				item.item_value};
			assign out_value  = rd0_data;
			assign result.sorted_value = out_value[PORT_BITS-1:0];
		end else if (VALUE_BITS == PORT_BITS) begin : g_same
			assign load_value = item.item_value;
			assign out_value  = rd0_data;
			assign result.sorted_value = out_value;
		end else begin : g_narrow
			assign load_value = item.item_value[VALUE_BITS-1:0];
			assign out_value  = rd0_data;
			assign result.sorted_value = {{(PORT_BITS - VALUE_BITS){out_value[VALUE_BITS-1]}},
				out_value};
		end
	endgenerate

	assign result.sorted_last   = flags.last;
	assign result.items_dropped = flags.dropped;
	assign strobe               = flags.valid;

	// Read data belongs to the store that was the source when the address went out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_b_s1 <= 1'b0;
		end else begin
			rd_b_s1 <= rd_b;
		end
	end

	assign rd0_data = rd_b_s1 ? b0_data : a0_data;
	assign rd1_data = rd_b_s1 ? b1_data : a1_data;

	mse_seq #(
		.MAX_ITEMS  (MAX_ITEMS),
		.VALUE_BITS (VALUE_BITS),
		.AW         (AW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.last       (item.item_last),
		.load_value (load_value),
		.busy       (busy),
		.rd0_addr   (rd0_addr),
		.rd1_addr   (rd1_addr),
		.rd_b       (rd_b),
		.rd0_data   (rd0_data),
		.rd1_data   (rd1_data),
		.wr_en      (wr_en),
		.wr_b       (wr_b),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.flags      (flags)
	);

	mse_ram #(
		.WIDTH     (VALUE_BITS),
		.ADDR_BITS (AW)
	) u_store_a (
		.clk      (clk),
		.wr_en    (wr_en && !wr_b),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd0_addr (rd0_addr),
		.rd1_addr (rd1_addr),
		.rd0_data (a0_data),
		.rd1_data (a1_data)
	);

	mse_ram #(
		.WIDTH     (VALUE_BITS),
		.ADDR_BITS (AW)
	) u_store_b (
		.clk      (clk),
		.wr_en    (wr_en && wr_b),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd0_addr (rd0_addr),
		.rd1_addr (rd1_addr),
		.rd0_data (b0_data),
		.rd1_data (b1_data)
	);

endmodule

`default_nettype wire

>>> src/mse_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mse_ram #(
	parameter int WIDTH     = 32,
	parameter int ADDR_BITS = 6
) (
	input  wire logic                 clk,
	input  wire logic                 wr_en,
	input  wire logic [ADDR_BITS-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]     wr_data,
	input  wire logic [ADDR_BITS-1:0] rd0_addr,
	input  wire logic [ADDR_BITS-1:0] rd1_addr,
	output logic      [WIDTH-1:0]     rd0_data,
	output logic      [WIDTH-1:0]     rd1_data
);

	localparam int DEPTH = 1 << ADDR_BITS;

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd0_data <= mem[rd0_addr];
		rd1_data <= mem[rd1_addr];
	end

endmodule

`default_nettype wire

>>> src/mse_seq.sv
`timescale 1ns / 1ps
`default_nettype none
`include "merge_sort_engine_defines.svh"

module mse_seq import mse_pkg::*; #(
	parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int AW         = $clog2(MAX_ITEMS)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic                  last,
	input  wire logic [VALUE_BITS-1:0] load_value,
	output logic                       busy,
	output logic      [AW-1:0]         rd0_addr,
	output logic      [AW-1:0]         rd1_addr,
	output logic                       rd_b,
	input  wire logic [VALUE_BITS-1:0] rd0_data,
	input  wire logic [VALUE_BITS-1:0] rd1_data,
	output logic                       wr_en,
	output logic                       wr_b,
	output logic      [AW-1:0]         wr_addr,
	output logic      [VALUE_BITS-1:0] wr_data,
	output mse_flags_t                 flags
);

	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int PW = CW + 2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PRIME,
		S_MERGE,
		S_OUT
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           count_q;
	logic                    ovf_q;
	logic [PW-1:0]           w_q;
	logic [PW-1:0]           lo_q;
	logic [CW-1:0]           mid_q;
	logic [CW-1:0]           hi_q;
	logic [CW-1:0]           i_q;
	logic [CW-1:0]           j_q;
	logic [CW-1:0]           k_q;
	logic                    src_b_q;
	logic                    took_a_q;
	logic                    took_b_q;
	logic [VALUE_BITS-1:0]   hold_a_q;
	logic [VALUE_BITS-1:0]   hold_b_q;
	mse_flags_t              flags_q;

	logic                    accept;
	logic                    room;
	logic [CW-1:0]           n_c;
	logic [VALUE_BITS-1:0]   head_a;
	logic [VALUE_BITS-1:0]   head_b;
	logic                    avail_a;
	logic                    avail_b;
	logic                    take_a;
	logic [CW-1:0]           i_inc;
	logic [CW-1:0]           j_inc;
	logic [CW-1:0]           k_inc;
	logic                    grp_end;
	logic [PW-1:0]           lo_next;
	logic [PW-1:0]           w_next;
	logic                    more_groups;
	logic [PW-1:0]           grp_lo;
	logic [PW-1:0]           grp_w;
	logic [PW-1:0]           sum_m;
	logic [PW-1:0]           sum_h;
	logic [CW-1:0]           grp_mid;
	logic [CW-1:0]           grp_hi;

	assign accept  = start && !busy;
	assign room    = count_q < CW'(MAX_ITEMS);
	assign n_c     = (state_q == S_IDLE && room) ? count_q + CW'(1) : count_q;
	assign busy    = (state_q != S_IDLE) || flags_q.valid;
	assign flags   = flags_q;
	assign rd_b    = src_b_q;

	// A head whose successor was fetched last cycle comes straight from the RAM output.
	assign head_a  = took_a_q ? rd0_data : hold_a_q;
	assign head_b  = took_b_q ? rd1_data : hold_b_q;
	assign avail_a = i_q < mid_q;
	assign avail_b = j_q < hi_q;
	assign take_a  = avail_a && (!avail_b || $signed(head_a) <= $signed(head_b));

	assign i_inc   = i_q + CW'(1);
	assign j_inc   = j_q + CW'(1);
	assign k_inc   = k_q + CW'(1);
	assign grp_end = k_inc == hi_q;
	assign w_next  = w_q << 1;
	assign lo_next = lo_q + w_next;
	assign more_groups = lo_next < PW'(n_c);

	// Bounds of the run pair that starts next.
	always_comb begin
		grp_lo = '0;
		grp_w  = w_q;
		unique case (state_q)
			S_IDLE: begin
				grp_w = PW'(1);
			end
			S_MERGE: begin
				if (more_groups) begin
					grp_lo = lo_next;
				end else begin
					grp_w = w_next;
				end
			end
			default: begin
				grp_w = w_q;
			end
		endcase
		sum_m   = grp_lo + grp_w;
		sum_h   = grp_lo + (grp_w << 1);
		grp_mid = (sum_m > PW'(n_c)) ? n_c : sum_m[CW-1:0];
		grp_hi  = (sum_h > PW'(n_c)) ? n_c : sum_h[CW-1:0];
	end

	always_comb begin
		rd0_addr = '0;
		rd1_addr = '0;
		wr_en    = 1'b0;
		wr_b     = 1'b0;
		wr_addr  = count_q[AW-1:0];
		wr_data  = load_value;
		unique case (state_q)
			S_IDLE: begin
				wr_en = accept && room;
			end
			S_PRIME: begin
				rd0_addr = i_q[AW-1:0];
				rd1_addr = j_q[AW-1:0];
			end
			S_MERGE: begin
				rd0_addr = i_inc[AW-1:0];
				rd1_addr = j_inc[AW-1:0];
				wr_en    = 1'b1;
				wr_b     = !src_b_q;
				wr_addr  = k_q[AW-1:0];
				wr_data  = take_a ? head_a : head_b;
			end
			S_OUT: begin
				rd0_addr = k_q[AW-1:0];
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			ovf_q    <= 1'b0;
			w_q      <= PW'(1);
			lo_q     <= '0;
			mid_q    <= '0;
			hi_q     <= '0;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			src_b_q  <= 1'b0;
			took_a_q <= 1'b0;
			took_b_q <= 1'b0;
			hold_a_q <= '0;
			hold_b_q <= '0;
			flags_q  <= '0;
		end else begin
			flags_q.valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (room) begin
							count_q <= n_c;
						end else begin
							ovf_q <= 1'b1;
						end
						if (last) begin
							w_q     <= PW'(1);
							src_b_q <= 1'b0;
							k_q     <= '0;
							if (n_c <= CW'(1)) begin
								state_q <= S_OUT;
							end else begin
								lo_q    <= '0;
								i_q     <= '0;
								j_q     <= grp_mid;
								mid_q   <= grp_mid;
								hi_q    <= grp_hi;
								state_q <= S_PRIME;
							end
						end
					end
				end
				S_PRIME: begin
					took_a_q <= 1'b1;
					took_b_q <= 1'b1;
					state_q  <= S_MERGE;
				end
				S_MERGE: begin
					hold_a_q <= head_a;
					hold_b_q <= head_b;
					took_a_q <= take_a;
					took_b_q <= !take_a;
					if (take_a) begin
						i_q <= i_inc;
					end else begin
						j_q <= j_inc;
					end
					k_q <= k_inc;
					if (grp_end) begin
						if (more_groups) begin
							lo_q    <= lo_next;
							i_q     <= grp_lo[CW-1:0];
							j_q     <= grp_mid;
							mid_q   <= grp_mid;
							hi_q    <= grp_hi;
							k_q     <= grp_lo[CW-1:0];
							state_q <= S_PRIME;
						end else begin
							src_b_q <= !src_b_q;
							w_q     <= w_next;
							k_q     <= '0;
							if (w_next >= PW'(n_c)) begin
								state_q <= S_OUT;
							end else begin
								lo_q    <= '0;
								i_q     <= '0;
								j_q     <= grp_mid;
								mid_q   <= grp_mid;
								hi_q    <= grp_hi;
								state_q <= S_PRIME;
							end
						end
					end
				end
				S_OUT: begin
					flags_q.valid   <= 1'b1;
					flags_q.last    <= k_inc == count_q;
					flags_q.dropped <= ovf_q;
					k_q             <= k_inc;
					if (k_inc == count_q) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						w_q     <= PW'(1);
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`MSE_ASSERT_IMPLY(a_merge_count, clk, arst_n, state_q == S_MERGE, ({1'b0, k_q} + {1'b0, mid_q}) == ({1'b0, i_q} + {1'b0, j_q}), "merge output index out of step with run pointers")
	`MSE_ASSERT_IMPLY(a_merge_bounds, clk, arst_n, state_q == S_MERGE, k_q < hi_q && i_q <= mid_q && j_q <= hi_q, "merge pointer beyond its run")
	`MSE_ASSERT_IMPLY(a_last_clears, clk, arst_n, flags_q.valid && flags_q.last, state_q == S_IDLE && count_q == '0 && !ovf_q, "set state not cleared at final result")
	`MSE_ASSERT_NEXT(a_prime_merge, clk, arst_n, state_q == S_PRIME, state_q == S_MERGE && took_a_q && took_b_q, "run heads not fetched before merge")

endmodule

`default_nettype wire

>>> tb/sv/merge_sort_engine_tb.sv
`timescale 1ns / 1ps

module merge_sort_engine_tb;
	import mse_pkg::*;

	localparam int ITEM_TARGET = 430;
	localparam int DRAIN_CYCLES = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	mse_item_t item = '0;
	logic strobe;
	mse_result_t result;

	mse_item_t pending_items[$];
	mse_result_t expected_results[$];
	logic signed [PORT_BITS-1:0] held_values[$];
	logic held_dropped = 1'b0;

	int fail_count = 0;
	int burst_left = 0;
	int gap_left = 0;
	bit accepted;
	mse_result_t want;

	merge_sort_engine u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.strobe(strobe),
		.result(result)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Mirror of the block: holds values of the open set and, on the last item,
	// sorts them and queues one expected result per held value.
	task automatic absorb_item(input mse_item_t it);
		logic signed [PORT_BITS-1:0] v;
		logic signed [PORT_BITS-1:0] key;
		logic signed [PORT_BITS-1:0] sorted[$];
		mse_result_t r;
		int j;
		v = (it.item_value <<< (PORT_BITS - VALUE_BITS_DEF)) >>> (PORT_BITS - VALUE_BITS_DEF);
		if (held_values.size() < MAX_ITEMS_DEF)
			held_values.push_back(v);
		else
			held_dropped = 1'b1;
		if (it.item_last) begin
			sorted = held_values;
			// Insertion sort keeps equal values in arrival order.
			for (int i = 1; i < sorted.size(); i++) begin
				key = sorted[i];
				j = i - 1;
				while (j >= 0 && sorted[j] > key) begin
					sorted[j + 1] = sorted[j];
					j--;
				end
				sorted[j + 1] = key;
			end
			for (int k = 0; k < sorted.size(); k++) begin
				r.sorted_value = sorted[k];
				r.sorted_last = (k == sorted.size() - 1);
				r.items_dropped = held_dropped;
				expected_results.push_back(r);
			end
			held_values.delete();
			held_dropped = 1'b0;
		end
	endtask

	// Driver: a transaction completes at an edge with start high and busy low.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
			burst_left <= $urandom_range(1, 12);
			gap_left <= 0;
		end else begin
			accepted = start && !busy;
			if (accepted)
				absorb_item(item);
			if (!start || accepted) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					start <= 1'b0;
				end else if (pending_items.size() != 0) begin
					item <= pending_items.pop_front();
					start <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every strobed result is matched against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got value %0d last %0b drop %0b",
					$time, result.sorted_value, result.sorted_last, result.items_dropped);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (result.sorted_value !== want.sorted_value) begin
					$display("%0t: sorted_value expected %0d got %0d",
						$time, want.sorted_value, result.sorted_value);
					fail_count++;
				end
				if (result.sorted_last !== want.sorted_last) begin
					$display("%0t: sorted_last expected %0b got %0b",
						$time, want.sorted_last, result.sorted_last);
					fail_count++;
				end
				if (result.items_dropped !== want.items_dropped) begin
					$display("%0t: items_dropped expected %0b got %0b",
						$time, want.items_dropped, result.items_dropped);
					fail_count++;
				end
			end
		end
	end

	task automatic push_item(input logic signed [PORT_BITS-1:0] v, input logic last);
		mse_item_t it;
		it.item_value = v;
		it.item_last = last;
		pending_items.push_back(it);
	endtask

	function automatic logic signed [PORT_BITS-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 4))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return 0;
					3: return -1;
					default: return 1;
				endcase
			end
			// A narrow range makes duplicate values common.
			1: return $signed($urandom_range(0, 8)) - 4;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_set(input int n);
		for (int i = 0; i < n; i++)
			push_item(pick_value(), i == n - 1);
	endtask

	initial begin
		int set_idx;
		int n;

		// Directed sets: a single value, the two extremes, duplicates and zero,
		// a reversed set and an already ordered set.
		push_item(32'sh8000_0000, 1'b1);
		push_item(32'sh7fff_ffff, 1'b0);
		push_item(32'sh8000_0000, 1'b1);
		push_item(0, 1'b0);
		push_item(-1, 1'b0);
		push_item(1, 1'b0);
		push_item(-1, 1'b0);
		push_item(0, 1'b1);
		push_item(32'sh7fff_ffff, 1'b0);
		push_item(1000, 1'b0);
		push_item(1, 1'b0);
		push_item(0, 1'b0);
		push_item(-1000, 1'b0);
		push_item(32'sh8000_0000, 1'b1);
		push_item(-3, 1'b0);
		push_item(-2, 1'b0);
		push_item(2, 1'b0);
		push_item(3, 1'b1);

		// Random sets: the first overflows capacity, the second fills it exactly,
		// later ones are mostly small with an occasional full or overflowing set.
		set_idx = 0;
		while (pending_items.size() < ITEM_TARGET) begin
			if (set_idx == 0)
				n = MAX_ITEMS_DEF + $urandom_range(1, 6);
			else if (set_idx == 1)
				n = MAX_ITEMS_DEF;
			else begin
				case ($urandom_range(0, 9))
					0: n = MAX_ITEMS_DEF + $urandom_range(1, 8);
					1: n = MAX_ITEMS_DEF;
					default: n = $urandom_range(1, 12);
				endcase
			end
			queue_set(n);
			set_idx++;
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Sampled away from the driving edge, so that the last item is known to be taken.
		while (pending_items.size() != 0 || start)
			@(negedge clk);
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#10ms;
		$display("FAIL");
		$finish;
	end

endmodule
